### rtl/kfi_pkg.sv
// ----------------------------------------------------------------------------
// kfi_pkg
// Shared constants, codes and types of the keyframe interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kfi_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int CHANNELS   = 4;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int VAL_W      = 32;
  localparam int WGT_W      = 17;
  localparam int STEP_W     = 6;

  localparam logic [15:0]       MIN_GAP_RESET  = 16'd655;
  localparam logic [WGT_W-1:0]  WEIGHT_ONE     = 17'h10000;
  localparam logic [STEP_W-1:0] DIV_FRAC_STEPS = 6'd16;
  localparam logic [STEP_W-1:0] DIV_FULL_STEPS = 6'd32;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SET       = 3'd1,
    CMD_APPEND    = 3'd2,
    CMD_LOOP      = 3'd3,
    CMD_INTERRUPT = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BANY, ST_SCAN, ST_GAP, ST_DROP, ST_SETL,
    ST_LADV_A, ST_LADV_B, ST_BL_S, ST_BL_E, ST_WGT, ST_DIV,
    ST_MUL, ST_MIX, ST_INT_WR, ST_APP0,
    ST_EL_LAST, ST_EL_FIRST, ST_EL_MAX, ST_EL_CHK, ST_EL_DIV,
    ST_EL_IDX, ST_EL_ADD, ST_FIN
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_cur;   // write current value instead of input value
    logic             ld_a;
    logic             ld_b;
    logic             mul_en;
    logic             cur_in;
    logic             cur_rd;
    logic             cur_mix;
  } lane_ctl_t;

  // logical frame index to slot of the circular table
  function automatic logic [IDX_W-1:0] kfi_phys(logic [IDX_W-1:0] b, logic [IDX_W-1:0] l);
    logic [IDX_W:0] s;
    s = {1'b0, b} + {1'b0, l};
    if (s >= (IDX_W+1)'(MAX_FRAMES)) s = s - (IDX_W+1)'(MAX_FRAMES);
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/kfi_div.sv
// ----------------------------------------------------------------------------
// kfi_div
// Restoring divider, one quotient bit per cycle, shared by blend and loop entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kfi_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                rem_init_i,
  input  wire logic [31:0]                dividend_i,
  input  wire logic [31:0]                divisor_i,
  input  wire logic [kfi_pkg::STEP_W-1:0] steps_i,
  output logic                            done_o,
  output logic [31:0]                     quot_o,
  output logic [31:0]                     rem_o
);
  import kfi_pkg::*;

  logic [31:0]       rem_q, rem_d, x_q, x_d, q_q, q_d, d_q, d_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [32:0]       trial;

  always_comb begin
    rem_d  = rem_q;
    x_d    = x_q;
    q_d    = q_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, x_q[31]};
    if (start_i) begin
      rem_d  = rem_init_i;
      x_d    = dividend_i;
      d_d    = divisor_i;
      q_d    = '0;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, d_q}) begin
        rem_d = 32'(trial - {1'b0, d_q});
        q_d   = {q_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        q_d   = {q_q[30:0], 1'b0};
      end
      x_d   = {x_q[30:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    x_q   <= x_d;
    q_q   <= q_d;
    d_q   <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### rtl/kfi_lane.sv
// ----------------------------------------------------------------------------
// kfi_lane
// One channel: keyframe value store, blend multiply and current value.
// ----------------------------------------------------------------------------
`default_nettype none

module kfi_lane (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire kfi_pkg::lane_ctl_t        ctl_i,
  input  wire logic [kfi_pkg::WGT_W-1:0] weight_i,
  input  wire logic [kfi_pkg::VAL_W-1:0] value_i,
  output logic      [kfi_pkg::VAL_W-1:0] cur_o
);
  import kfi_pkg::*;

  logic [VAL_W-1:0] vals_q [MAX_FRAMES];
  logic [VAL_W-1:0] rd, a_q, b_q, cur_q, cur_d;
  logic signed [VAL_W:0]   diff;
  logic signed [VAL_W+WGT_W+1:0] p_q;

  assign rd   = vals_q[ctl_i.rd_idx];
  assign diff = $signed({b_q[VAL_W-1], b_q}) - $signed({a_q[VAL_W-1], a_q});

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) vals_q[ctl_i.wr_idx] <= ctl_i.wr_cur ? cur_q : value_i;
    if (ctl_i.ld_a) a_q <= rd;
    if (ctl_i.ld_b) b_q <= rd;
    if (ctl_i.mul_en) p_q <= diff * $signed({1'b0, weight_i});
  end

  // blended offset rounds toward minus infinity: plain arithmetic shift
  always_comb begin
    cur_d = cur_q;
    if (ctl_i.cur_in)       cur_d = value_i;
    else if (ctl_i.cur_rd)  cur_d = rd;
    else if (ctl_i.cur_mix) cur_d = a_q + p_q[VAL_W+15:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cur_q <= '0;
    else         cur_q <= cur_d;
  end

  assign cur_o = cur_q;

endmodule

`default_nettype wire

### rtl/keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_interpolator
// Keyframe table with linear blend across parallel channel lanes.
// ----------------------------------------------------------------------------
// Set, append and unused codes go straight to the result state (the append of a
//   second frame passes through ST_APP0); a tick scans or advances the table, an interrupt
//   adds a write-back, and the divider runs only for a fractional weight or on loop entry.
// Throughput: one command at a time, set by the sequencer's single time-table
//   read port and the bit-serial divider. done_o marks a one-cycle result.
// Reset clears control state and current values; table entries are unknown.
`default_nettype none

module keyframe_interpolator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] timestamp_i,
  input  wire logic [31:0] key_time_i,
  input  wire logic [31:0] value_a_i,
  input  wire logic [31:0] value_b_i,
  input  wire logic [31:0] value_c_i,
  input  wire logic [31:0] value_d_i,
  input  wire logic [31:0] loop_offset_i,
  output logic             done_o,
  output logic [31:0]      out_a_o,
  output logic [31:0]      out_b_o,
  output logic [31:0]      out_c_o,
  output logic [31:0]      out_d_o,
  output logic             settled_o,
  output logic             table_full_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  import kfi_pkg::*;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;

  logic [31:0]      times_q [MAX_FRAMES];
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d;
  logic [IDX_W-1:0] base_q, base_d, pos_q, pos_d, s_q, s_d, e_q, e_d;
  logic [31:0]      period_q, period_d, now_q, now_d, t0_q, t0_d, t1_q, t1_d;
  logic [31:0]      tmax_q, tmax_d, off_q, off_d;
  logic [32:0]      shift_q, shift_d;
  logic [WGT_W-1:0] w_q, w_d;
  logic             active_q, active_d, settled_q, settled_d, full_q, full_d;
  logic [15:0]      min_gap_q;

  logic [IDX_W-1:0] rd_log, tw_log, wr_log, back;
  logic [31:0]      t_rd, tw_dat;
  logic             tw_en;
  lane_ctl_t        lctl;
  logic [VAL_W-1:0] vin [CHANNELS];
  logic [VAL_W-1:0] cur [CHANNELS];

  logic             div_start, div_done;
  logic [31:0]      div_rinit, div_x, div_d, div_q, div_r;
  logic [STEP_W-1:0] div_steps;

  logic signed [32:0] num, den, gap;
  logic signed [33:0] per_s;
  logic [CNT_W:0]     i_inc;
  logic [CNT_W-1:0]   step;
  logic [33:0]        tsum;

  assign t_rd  = times_q[kfi_phys(base_q, rd_log)];
  assign i_inc = {1'b0, i_q} + 1'b1;
  assign back  = (pos_q != '0) ? pos_q - 1'b1 : IDX_W'(cnt_q - 1'b1);
  assign num   = $signed({1'b0, now_q}) - $signed({1'b0, t0_q});
  assign den   = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
  assign gap   = $signed({1'b0, t_rd}) - $signed({1'b0, t0_q});
  assign per_s = $signed({2'b0, t1_q}) - $signed({2'b0, t_rd}) + $signed({2'b0, off_q});
  assign step  = i_q - 1'b1;
  assign tsum  = {2'b0, t_rd} + {1'b0, shift_q};

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    base_d    = base_q;
    pos_d     = pos_q;
    s_d       = s_q;
    e_d       = e_q;
    period_d  = period_q;
    now_d     = now_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    tmax_d    = tmax_q;
    off_d     = off_q;
    shift_d   = shift_q;
    w_d       = w_q;
    active_d  = active_q;
    settled_d = settled_q;
    full_d    = full_q;
    rd_log    = '0;
    tw_en     = 1'b0;
    tw_log    = '0;
    tw_dat    = '0;
    wr_log    = '0;
    lctl      = '0;
    div_start = 1'b0;
    div_rinit = '0;
    div_x     = '0;
    div_d     = '0;
    div_steps = DIV_FRAC_STEPS;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          settled_d = 1'b0;
          full_d    = 1'b0;
          cmd_d     = cmd_e'(cmd_i);
          state_d   = ST_FIN;
          unique case (cmd_e'(cmd_i))
            CMD_TICK: begin
              now_d   = timestamp_i;
              state_d = ST_BANY;
            end
            CMD_SET: begin
              cnt_d       = CNT_W'(1);
              lctl.cur_in = 1'b1;
              lctl.wr_en  = 1'b1;
            end
            CMD_APPEND: begin
              if (cnt_q >= CNT_W'(MAX_FRAMES)) begin
                full_d = 1'b1;
              end else begin
                wr_log     = IDX_W'(cnt_q);
                lctl.wr_en = 1'b1;
                tw_en      = 1'b1;
                tw_log     = IDX_W'(cnt_q);
                tw_dat     = key_time_i;
                cnt_d      = cnt_q + 1'b1;
                if (cnt_q == CNT_W'(1)) state_d = ST_APP0;
              end
            end
            CMD_LOOP: begin
              off_d = loop_offset_i;
              if (cnt_q >= CNT_W'(2)) state_d = ST_EL_LAST;
            end
            CMD_INTERRUPT: state_d = ST_BANY;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_APP0: begin
        tw_en   = 1'b1;
        tw_dat  = now_q;
        state_d = ST_FIN;
      end
      ST_BANY: begin
        i_d = '0;
        if (cnt_q < CNT_W'(2)) begin
          state_d = (cmd_q == CMD_INTERRUPT) ? ST_INT_WR : ST_FIN;
        end else if (active_q) begin
          if ({1'b0, pos_q} >= CNT_W'(cnt_q)) pos_d = '0;
          state_d = ST_LADV_A;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_log = IDX_W'(i_q);
        t0_d   = t_rd;
        if (i_q < cnt_q && t_rd < now_q) i_d = i_q + 1'b1;
        else state_d = ST_GAP;
      end
      ST_GAP: begin
        rd_log = IDX_W'(i_inc);
        if (i_inc < {1'b0, cnt_q} && gap < $signed({17'b0, min_gap_q})) begin
          t0_d = t_rd;
          i_d  = i_q + 1'b1;
        end else begin
          state_d = ST_DROP;
        end
      end
      ST_DROP: begin
        s_d     = '0;
        e_d     = IDX_W'(1);
        state_d = ST_BL_S;
        if (i_q > CNT_W'(1)) begin
          base_d = kfi_phys(base_q, IDX_W'(step));
          cnt_d  = cnt_q - step;
          if (cnt_q - step == CNT_W'(1)) state_d = ST_SETL;
        end
      end
      ST_SETL: begin
        lctl.cur_rd = 1'b1;
        // only a tick reports settling
        settled_d   = (cmd_q == CMD_TICK);
        state_d     = (cmd_q == CMD_INTERRUPT) ? ST_INT_WR : ST_FIN;
      end
      ST_LADV_A: begin
        rd_log = pos_q;
        if (i_q < CNT_W'(MAX_FRAMES) && t_rd <= now_q) begin
          state_d = ST_LADV_B;
        end else begin
          s_d     = back;
          e_d     = pos_q;
          state_d = ST_BL_S;
        end
      end
      ST_LADV_B: begin
        rd_log  = back;
        tw_en   = 1'b1;
        tw_log  = back;
        tw_dat  = t_rd + period_q;
        pos_d   = ({1'b0, pos_q} + 1'b1 == cnt_q) ? '0 : pos_q + 1'b1;
        i_d     = i_q + 1'b1;
        state_d = ST_LADV_A;
      end
      ST_BL_S: begin
        rd_log    = s_q;
        t0_d      = t_rd;
        lctl.ld_a = 1'b1;
        state_d   = ST_BL_E;
      end
      ST_BL_E: begin
        rd_log    = e_q;
        t1_d      = t_rd;
        lctl.ld_b = 1'b1;
        state_d   = ST_WGT;
      end
      ST_WGT: begin
        state_d = ST_MUL;
        if (den <= 0) begin
          w_d = (num >= 0) ? WEIGHT_ONE : '0;
        end else if (num <= 0) begin
          w_d = '0;
        end else if (num >= den) begin
          w_d = WEIGHT_ONE;
        end else begin
          div_start = 1'b1;
          div_rinit = num[31:0];
          div_d     = den[31:0];
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          w_d     = {1'b0, div_q[15:0]};
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        lctl.mul_en = 1'b1;
        state_d     = ST_MIX;
      end
      ST_MIX: begin
        lctl.cur_mix = 1'b1;
        state_d      = (cmd_q == CMD_INTERRUPT) ? ST_INT_WR : ST_FIN;
      end
      ST_INT_WR: begin
        lctl.wr_en  = 1'b1;
        lctl.wr_cur = 1'b1;
        active_d    = 1'b0;
        cnt_d       = CNT_W'(1);
        state_d     = ST_FIN;
      end
      ST_EL_LAST: begin
        rd_log  = IDX_W'(cnt_q - 1'b1);
        t1_d    = t_rd;
        state_d = ST_EL_FIRST;
      end
      ST_EL_FIRST: begin
        rd_log = '0;
        i_d    = '0;
        tmax_d = '0;
        if (per_s <= 0) begin
          state_d = ST_FIN;
        end else begin
          period_d = per_s[32] ? 32'hFFFF_FFFF : per_s[31:0];
          active_d = 1'b1;
          state_d  = ST_EL_MAX;
        end
      end
      ST_EL_MAX: begin
        rd_log = IDX_W'(i_q);
        if (i_q < cnt_q) begin
          if (t_rd > tmax_q) tmax_d = t_rd;
          i_d = i_q + 1'b1;
        end else begin
          state_d = ST_EL_CHK;
        end
      end
      ST_EL_CHK: begin
        i_d = '0;
        if (tmax_q > now_q) begin
          shift_d = '0;
          state_d = ST_EL_IDX;
        end else begin
          div_start = 1'b1;
          div_x     = now_q - tmax_q;
          div_d     = period_q;
          div_steps = DIV_FULL_STEPS;
          state_d   = ST_EL_DIV;
        end
      end
      ST_EL_DIV: begin
        // whole periods that fit past the latest frame, plus one
        if (div_done) begin
          shift_d = {1'b0, now_q - tmax_q} - {1'b0, div_r} + {1'b0, period_q};
          state_d = ST_EL_IDX;
        end
      end
      ST_EL_IDX: begin
        rd_log = IDX_W'(i_q);
        if (i_q < cnt_q && tsum <= {2'b0, now_q}) begin
          i_d = i_q + 1'b1;
        end else begin
          pos_d   = (i_q >= cnt_q) ? '0 : IDX_W'(i_q);
          i_d     = '0;
          state_d = ST_EL_ADD;
        end
      end
      ST_EL_ADD: begin
        rd_log = IDX_W'(i_q);
        if (i_q < cnt_q) begin
          tw_en  = 1'b1;
          tw_log = IDX_W'(i_q);
          tw_dat = tsum[31:0];
          i_d    = i_q + 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase

    lctl.rd_idx = kfi_phys(base_q, rd_log);
    lctl.wr_idx = kfi_phys(base_q, wr_log);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= CMD_TICK;
      cnt_q     <= '0;
      i_q       <= '0;
      base_q    <= '0;
      pos_q     <= '0;
      period_q  <= '0;
      now_q     <= '0;
      active_q  <= 1'b0;
      settled_q <= 1'b0;
      full_q    <= 1'b0;
      min_gap_q <= MIN_GAP_RESET;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      cnt_q     <= cnt_d;
      i_q       <= i_d;
      base_q    <= base_d;
      pos_q     <= pos_d;
      period_q  <= period_d;
      now_q     <= now_d;
      active_q  <= active_d;
      settled_q <= settled_d;
      full_q    <= full_d;
      if (cfg_valid_i) min_gap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    e_q     <= e_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    tmax_q  <= tmax_d;
    off_q   <= off_d;
    shift_q <= shift_d;
    w_q     <= w_d;
    if (tw_en) times_q[kfi_phys(base_q, tw_log)] <= tw_dat;
  end

  kfi_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .rem_init_i (div_rinit),
    .dividend_i (div_x),
    .divisor_i  (div_d),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    if (c == 0)      assign vin[c] = value_a_i;
    else if (c == 1) assign vin[c] = value_b_i;
    else if (c == 2) assign vin[c] = value_c_i;
    else if (c == 3) assign vin[c] = value_d_i;
    else             assign vin[c] = '0;

    kfi_lane u_lane (
      .clk_i,
      .rst_ni,
      .ctl_i    (lctl),
      .weight_i (w_q),
      .value_i  (vin[c]),
      .cur_o    (cur[c])
    );
  end

  // result merge: lane values onto the result ports
  assign out_a_o      = (CHANNELS > 0) ? cur[0] : '0;
  assign out_b_o      = (CHANNELS > 1) ? cur[1 % CHANNELS] : '0;
  assign out_c_o      = (CHANNELS > 2) ? cur[2 % CHANNELS] : '0;
  assign out_d_o      = (CHANNELS > 3) ? cur[3 % CHANNELS] : '0;
  assign settled_o    = settled_q;
  assign table_full_o = full_q;
  assign done_o       = (state_q == ST_FIN);
  assign busy_o       = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("sequencer not idle after result");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAMES))
    else $error("frame count beyond table size");
  a_full_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && done_o |-> cmd_q == CMD_APPEND)
    else $error("table_full on a non-append transaction");
`endif

endmodule

`default_nettype wire
